// ===== design/nmea_sentence_framer_talker_rewrite_core_defines.svh =====
// Assertion macros for the NMEA sentence framer core.
// Used by the top level; depends on nothing else.
`ifndef NMEA_SENTENCE_FRAMER_TALKER_REWRITE_CORE_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_TALKER_REWRITE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NMEA_FR_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nmea_fr check failed");

// Next-cycle implication, disabled during reset.
`define NMEA_FR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nmea_fr check failed");

`endif

// ===== design/nmea_fr_pkg.sv =====
// Shared constants, types and helper functions of the NMEA sentence framer.
// No dependencies; queue, both ends, core and bench use it by scoped names.
package nmea_fr_pkg;

  localparam int BUF_LEN = 128;
  localparam int FILL_W  = $clog2(BUF_LEN);
  localparam int LEN_W   = $clog2(BUF_LEN + 1);
  localparam int ROW_W   = FILL_W - 3;
  localparam int RAM_AW  = ROW_W + 1;
  localparam int LANES   = 8;
  localparam int BANKS   = 2;
  localparam int BUSY_W  = $clog2(BANKS + 1);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int MIN_REWRITE_LEN = 8;
  localparam int PREFIX_LEN = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_P      = 8'h50;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_SEND
  } back_state_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             rewrite;
    logic [7:0]       hex_hi;
    logic [7:0]       hex_lo;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [LANES-1:0]  be;
    logic [LANES*8-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = CH_G;
      3'd2:    c = CH_N;
      3'd3:    c = CH_G;
      3'd4:    c = CH_G;
      3'd5:    c = CH_A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h57 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

// ===== design/nmea_fr_rx_if.sv =====
// Byte input channel of the NMEA sentence framer: valid/ready plus one byte.
// Depends on nothing.
interface nmea_fr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/nmea_fr_chunk_if.sv =====
// Chunk output channel of the NMEA sentence framer: valid/ready plus payload.
// Depends on nothing.
interface nmea_fr_chunk_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output out_bytes, output byte_count, output last,
                  input ready);
  modport sink (input valid, input out_bytes, input byte_count, input last,
                output ready);
endinterface

// ===== design/nmea_fr_ram.sv =====
// Generic byte-lane-writable RAM with one write port and one registered read port.
// Depends on nothing.
module nmea_fr_ram #(
  parameter int ADDR_W = 5,
  parameter int LANES  = 8
) (
  input  logic                clk,
  input  logic                wen,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [LANES-1:0]    be,
  input  logic [LANES*8-1:0]  wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [LANES*8-1:0]  rdata
);

  logic [LANES*8-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wen) begin
      for (int i = 0; i < LANES; i++) begin
        if (be[i]) begin
          mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/nmea_fr_queue.sv =====
// Short descriptor queue between the framing front end and the emitting back end.
// Depends on nmea_fr_pkg.
module nmea_fr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  nmea_fr_pkg::desc_t    push_desc,
  input  logic                  pop,
  output nmea_fr_pkg::desc_t    head,
  output nmea_fr_pkg::q_status_t status
);

  logic [nmea_fr_pkg::QPTR_W-1:0] rd_ptr;
  logic [nmea_fr_pkg::QPTR_W-1:0] wr_ptr;
  logic [nmea_fr_pkg::QCNT_W-1:0] count;
  nmea_fr_pkg::desc_t entries [nmea_fr_pkg::QDEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + nmea_fr_pkg::QCNT_W'(push) - nmea_fr_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  assign head            = entries[rd_ptr];
  assign status.nonempty = (count != '0);
  assign status.full     = (count == nmea_fr_pkg::QCNT_W'(nmea_fr_pkg::QDEPTH));

endmodule

// ===== design/nmea_fr_front.sv =====
// Front end: hunts for '$', stores sentence bytes into a free bank, tracks the
// talker prefix and checksum, and queues a descriptor per complete sentence.
// Depends on nmea_fr_pkg and nmea_fr_rx_if.
module nmea_fr_front (
  input  logic                 clk,
  input  logic                 rst,
  nmea_fr_rx_if.sink           rx,
  input  logic                 done,
  output logic                 push,
  output nmea_fr_pkg::desc_t   desc,
  output nmea_fr_pkg::ram_wr_t wr
);

  logic [nmea_fr_pkg::FILL_W-1:0] fill;
  logic [nmea_fr_pkg::FILL_W-1:0] fill_next;
  logic [nmea_fr_pkg::BUSY_W-1:0] busy;
  logic [nmea_fr_pkg::BUSY_W-1:0] busy_next;
  logic                           wr_bank;
  logic                           wr_bank_next;
  logic [7:0]                     taps [4];
  logic [7:0]                     xsum;
  logic                           prefix_ok;

  logic [7:0]                     b;
  logic                           acc;
  logic                           active;
  logic                           is_lf;
  logic                           commit;
  logic [nmea_fr_pkg::LEN_W-1:0]  len;
  logic [7:0]                     cks;

  assign b      = rx.rx_byte;
  assign acc    = rx.valid && rx.ready;
  assign active = (fill != '0);
  assign is_lf  = (b == nmea_fr_pkg::CH_LF);
  assign len    = nmea_fr_pkg::LEN_W'(fill) + 1'b1;
  assign commit = acc && active && is_lf && (taps[0] == nmea_fr_pkg::CH_CR);
  assign push   = commit;

  assign rx.ready = (busy != nmea_fr_pkg::BUSY_W'(nmea_fr_pkg::BANKS));

  assign cks = xsum ^ taps[0] ^ taps[1] ^ taps[2] ^ taps[3]
             ^ nmea_fr_pkg::CH_N ^ nmea_fr_pkg::CH_P;

  assign desc.bank    = wr_bank;
  assign desc.len     = len;
  assign desc.rewrite = prefix_ok
                      && (len >= nmea_fr_pkg::LEN_W'(nmea_fr_pkg::MIN_REWRITE_LEN));
  assign desc.hex_hi  = nmea_fr_pkg::hex_char(cks[7:4]);
  assign desc.hex_lo  = nmea_fr_pkg::hex_char(cks[3:0]);

  assign wr.en   = acc && (active || (b == nmea_fr_pkg::CH_DOLLAR));
  assign wr.addr = {wr_bank, fill[nmea_fr_pkg::FILL_W-1:3]};
  assign wr.be   = nmea_fr_pkg::LANES'(1) << fill[2:0];
  assign wr.data = {nmea_fr_pkg::LANES{b}};

  always_comb begin
    fill_next = fill;
    if (acc) begin
      if (!active) begin
        if (b == nmea_fr_pkg::CH_DOLLAR) begin
          fill_next = nmea_fr_pkg::FILL_W'(1);
        end
      end else if (is_lf) begin
        fill_next = '0;
      end else if (len == nmea_fr_pkg::LEN_W'(nmea_fr_pkg::BUF_LEN)) begin
        fill_next = '0;
      end else begin
        fill_next = nmea_fr_pkg::FILL_W'(len);
      end
    end
    wr_bank_next = commit ? ~wr_bank : wr_bank;
    busy_next = busy + nmea_fr_pkg::BUSY_W'(commit) - nmea_fr_pkg::BUSY_W'(done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      busy    <= '0;
      wr_bank <= 1'b0;
    end else begin
      fill    <= fill_next;
      busy    <= busy_next;
      wr_bank <= wr_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !active && (b == nmea_fr_pkg::CH_DOLLAR)) begin
      taps[0]   <= b;
      xsum      <= 8'h00;
      prefix_ok <= 1'b1;
    end else if (acc && active) begin
      taps[0] <= b;
      taps[1] <= taps[0];
      taps[2] <= taps[1];
      taps[3] <= taps[2];
      xsum    <= xsum ^ b;
      if (fill < nmea_fr_pkg::FILL_W'(nmea_fr_pkg::PREFIX_LEN)) begin
        prefix_ok <= prefix_ok && (b == nmea_fr_pkg::prefix_char(fill[2:0]));
      end
    end
  end

endmodule

// ===== design/nmea_fr_back.sv =====
// Back end: reads a queued sentence row by row, patches talker and checksum
// bytes, masks unused lanes, and holds each chunk in the output register.
// Depends on nmea_fr_pkg and nmea_fr_chunk_if.
module nmea_fr_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  nmea_fr_pkg::desc_t                       head,
  input  nmea_fr_pkg::q_status_t                   qstat,
  input  logic [nmea_fr_pkg::LANES*8-1:0]          rdata,
  output logic [nmea_fr_pkg::RAM_AW-1:0]           raddr,
  output logic                                     done,
  nmea_fr_chunk_if.source                          chunk
);

  nmea_fr_pkg::back_state_t state;
  nmea_fr_pkg::back_state_t state_next;

  logic [nmea_fr_pkg::ROW_W-1:0]   row;
  logic [nmea_fr_pkg::LANES*8-1:0] out_word;
  logic [3:0]                      out_count;
  logic                            out_last;

  logic [nmea_fr_pkg::LEN_W-1:0]   rem;
  logic                            is_last;
  logic [3:0]                      count;
  logic [nmea_fr_pkg::LANES*8-1:0] patched;

  assign raddr   = {head.bank, row};
  assign rem     = head.len - nmea_fr_pkg::LEN_W'({row, 3'b000});
  assign is_last = (rem <= nmea_fr_pkg::LEN_W'(nmea_fr_pkg::LANES));
  assign count   = is_last ? rem[3:0] : 4'(nmea_fr_pkg::LANES);

  always_comb begin
    logic [nmea_fr_pkg::LEN_W-1:0] pos;
    logic [7:0]                    lane;
    patched = '0;
    for (int j = 0; j < nmea_fr_pkg::LANES; j++) begin
      pos  = nmea_fr_pkg::LEN_W'({row, 3'(j)});
      lane = rdata[j*8 +: 8];
      if (head.rewrite) begin
        if (pos == nmea_fr_pkg::LEN_W'(2)) begin
          lane = nmea_fr_pkg::CH_P;
        end else if (pos == head.len - nmea_fr_pkg::LEN_W'(4)) begin
          lane = head.hex_hi;
        end else if (pos == head.len - nmea_fr_pkg::LEN_W'(3)) begin
          lane = head.hex_lo;
        end
      end
      if (pos >= head.len) begin
        lane = 8'h00;
      end
      patched[j*8 +: 8] = lane;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      nmea_fr_pkg::B_IDLE: begin
        if (qstat.nonempty) begin
          state_next = nmea_fr_pkg::B_READ;
        end
      end
      nmea_fr_pkg::B_READ: begin
        state_next = nmea_fr_pkg::B_LOAD;
      end
      nmea_fr_pkg::B_LOAD: begin
        state_next = nmea_fr_pkg::B_SEND;
      end
      nmea_fr_pkg::B_SEND: begin
        if (chunk.ready) begin
          if (out_last) begin
            done       = 1'b1;
            state_next = nmea_fr_pkg::B_IDLE;
          end else begin
            state_next = nmea_fr_pkg::B_READ;
          end
        end
      end
      default: begin
        state_next = nmea_fr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nmea_fr_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == nmea_fr_pkg::B_IDLE) begin
      row <= '0;
    end else if ((state == nmea_fr_pkg::B_SEND) && chunk.ready && !out_last) begin
      row <= row + 1'b1;
    end
    if (state == nmea_fr_pkg::B_LOAD) begin
      out_word  <= patched;
      out_count <= count;
      out_last  <= is_last;
    end
  end

  assign chunk.valid      = (state == nmea_fr_pkg::B_SEND);
  assign chunk.out_bytes  = out_word;
  assign chunk.byte_count = out_count;
  assign chunk.last       = out_last;

endmodule

// ===== design/nmea_sentence_framer_talker_rewrite_core.sv =====
// NMEA 0183 sentence framer with GNGGA-to-GPGGA talker rewrite. Received bytes
// enter at one per clock while a sentence bank is free; the block holds two
// banks, so input stalls only when two finished sentences still await output.
// Each output chunk of up to eight bytes goes through a RAM row read, the
// checksum patch and the output register, then waits for ready; the next row
// is read only once the chunk is taken; the back end idles between sentences.
// A complete sentence is emitted only after its newline has been received.
`include "nmea_sentence_framer_talker_rewrite_core_defines.svh"

module nmea_sentence_framer_talker_rewrite_core (
  input  logic            clk,
  input  logic            rst,
  nmea_fr_rx_if.sink      rx,
  nmea_fr_chunk_if.source chunk
);

  logic                                  push;
  logic                                  done;
  nmea_fr_pkg::desc_t                    push_desc;
  nmea_fr_pkg::desc_t                    head;
  nmea_fr_pkg::q_status_t                qstat;
  nmea_fr_pkg::ram_wr_t                  wr;
  logic [nmea_fr_pkg::RAM_AW-1:0]        raddr;
  logic [nmea_fr_pkg::LANES*8-1:0]       rdata;

  nmea_fr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .done (done),
    .push (push),
    .desc (push_desc),
    .wr   (wr)
  );

  nmea_fr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (done),
    .head      (head),
    .status    (qstat)
  );

  nmea_fr_ram #(
    .ADDR_W (nmea_fr_pkg::RAM_AW),
    .LANES  (nmea_fr_pkg::LANES)
  ) u_ram (
    .clk   (clk),
    .wen   (wr.en),
    .waddr (wr.addr),
    .be    (wr.be),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  nmea_fr_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .rdata (rdata),
    .raddr (raddr),
    .done  (done),
    .chunk (chunk)
  );

  `NMEA_FR_ASSERT_IMPLY(a_no_push_full, clk, rst, push, !qstat.full)
  `NMEA_FR_ASSERT_IMPLY(a_valid_has_desc, clk, rst, chunk.valid, qstat.nonempty)
  `NMEA_FR_ASSERT_IMPLY(a_count_range, clk, rst, chunk.valid, (chunk.byte_count != 4'd0) && (chunk.byte_count <= 4'd8))
  `NMEA_FR_ASSERT_IMPLY(a_full_mid_chunk, clk, rst, chunk.valid && chunk.ready && !chunk.last, chunk.byte_count == 4'd8)
  `NMEA_FR_ASSERT_NEXT(a_gap_after_chunk, clk, rst, chunk.valid && chunk.ready, !chunk.valid)

endmodule

// ===== tb/tb_nmea_sentence_framer_talker_rewrite_core.sv =====
// Self-checking testbench for the NMEA sentence framer with GNGGA talker rewrite.
// Depends on nmea_fr_pkg, the nmea_fr_rx_if / nmea_fr_chunk_if interfaces and the core;
// a byte-level sentence predictor checks every output chunk in order.
module tb_nmea_sentence_framer_talker_rewrite_core;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          TOTAL_ITEMS  = 460;
  localparam logic [47:0] TALKER_GNGGA = {nmea_fr_pkg::CH_A, nmea_fr_pkg::CH_G,
                                          nmea_fr_pkg::CH_G, nmea_fr_pkg::CH_N,
                                          nmea_fr_pkg::CH_G, nmea_fr_pkg::CH_DOLLAR};

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } chunk_t;

  logic clk;
  logic rst;

  nmea_fr_rx_if    rx_if ();
  nmea_fr_chunk_if chunk_if ();

  nmea_sentence_framer_talker_rewrite_core dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if),
    .chunk (chunk_if)
  );

  chunk_t      expected_chunks[$];
  logic [7:0]  sentence_buf[nmea_fr_pkg::BUF_LEN];
  int unsigned sentence_fill;
  logic [7:0]  sentence_prev;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_hold;
  int unsigned sent_bytes;
  int unsigned framed_bytes;
  int unsigned chunks_seen;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h61 + {4'h0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == nmea_fr_pkg::CH_LF);
    return b;
  endfunction

  function automatic int unsigned pick_len(input int unsigned lo);
    if ($urandom_range(15) == 0) return $urandom_range(nmea_fr_pkg::BUF_LEN, lo);
    return $urandom_range(lo + 24, lo);
  endfunction

  // Advance the sentence predictor by one byte; took is low for bytes ignored while idle.
  task automatic frame_byte(input logic [7:0] b, output bit took);
    int unsigned len;
    int unsigned pos;
    int unsigned n;
    bit          match;
    logic [7:0]  sum;
    chunk_t      c;
    took = 1'b1;
    if (sentence_fill == 0) begin
      if (b == nmea_fr_pkg::CH_DOLLAR) begin
        sentence_buf[0] = b;
        sentence_fill = 1;
        sentence_prev = b;
      end else begin
        took = 1'b0;
      end
      return;
    end
    sentence_buf[sentence_fill] = b;
    sentence_fill++;
    len = sentence_fill;
    if (b != nmea_fr_pkg::CH_LF) begin
      sentence_prev = b;
      if (sentence_fill >= nmea_fr_pkg::BUF_LEN) sentence_fill = 0;
      return;
    end
    sentence_fill = 0;
    if (len <= 2 || sentence_prev != nmea_fr_pkg::CH_CR) begin
      sentence_prev = b;
      return;
    end
    sentence_prev = b;
    match = (len >= nmea_fr_pkg::MIN_REWRITE_LEN);
    for (int i = 0; i < nmea_fr_pkg::PREFIX_LEN; i++)
      if (sentence_buf[i] != TALKER_GNGGA[8*i +: 8]) match = 1'b0;
    if (match) begin
      sentence_buf[2] = nmea_fr_pkg::CH_P;
      sum = 8'h00;
      for (int i = 1; i <= int'(len) - 6; i++) sum ^= sentence_buf[i];
      sentence_buf[len-4] = hex_ascii(sum[7:4]);
      sentence_buf[len-3] = hex_ascii(sum[3:0]);
    end
    for (pos = 0; pos < len; pos += n) begin
      n = (len - pos > 8) ? 8 : len - pos;
      c.out_bytes = '0;
      for (int j = 0; j < int'(n); j++) c.out_bytes[8*j +: 8] = sentence_buf[pos+j];
      c.byte_count = 4'(n);
      c.last = (pos + n >= len);
      expected_chunks.push_back(c);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit took;
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    sent_bytes++;
    frame_byte(b, took);
    if (took) framed_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(nmea_fr_pkg::CH_CR);
    send_byte(nmea_fr_pkg::CH_LF);
  endtask

  task automatic wait_drain();
    rx_if.valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_sentence();
    int unsigned tot;
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: begin
        tot = pick_len(8);
        send_text("$GNGGA");
        repeat (tot - 8) send_byte(body_byte());
        send_byte(nmea_fr_pkg::CH_CR);
        send_byte(nmea_fr_pkg::CH_LF);
      end
      9, 10, 11, 12, 13: begin
        tot = pick_len(3);
        send_byte(nmea_fr_pkg::CH_DOLLAR);
        repeat (tot - 3) send_byte(body_byte());
        send_byte(nmea_fr_pkg::CH_CR);
        send_byte(nmea_fr_pkg::CH_LF);
      end
      14, 15, 16, 17: begin
        case ($urandom_range(7))
          0: begin
            send_byte(nmea_fr_pkg::CH_DOLLAR);
            repeat (nmea_fr_pkg::BUF_LEN - 1) send_byte(body_byte());
          end
          1, 2, 3: begin
            send_byte(nmea_fr_pkg::CH_DOLLAR);
            repeat ($urandom_range(20)) send_byte(body_byte());
            send_byte(nmea_fr_pkg::CH_LF);
          end
          default: begin
            send_byte(nmea_fr_pkg::CH_DOLLAR);
            repeat ($urandom_range(30, 1)) send_byte(8'($urandom_range(255)));
          end
        endcase
      end
      default: repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
    endcase
  endtask

  task automatic test_framing();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(nmea_fr_pkg::CH_LF);
    send_byte(nmea_fr_pkg::CH_CR);
    send_text("$\n");
    send_text("$A\n");
    send_line("$");
    send_line("$A$B");
    send_byte(nmea_fr_pkg::CH_DOLLAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(nmea_fr_pkg::CH_CR);
    send_byte(nmea_fr_pkg::CH_LF);
    wait_drain();
  endtask

  task automatic test_talker_rewrite();
    send_line("$GNGGA");
    send_line("$GNGG");
    send_line("$GNGGA,q*00");
    send_line("$GNGGA,1234,N*00");
    send_line("$GPGGA,1234*00");
    wait_drain();
  endtask

  task automatic test_length_limits();
    send_text("$GNGGA");
    repeat (nmea_fr_pkg::BUF_LEN - 8) send_byte(body_byte());
    send_byte(nmea_fr_pkg::CH_CR);
    send_byte(nmea_fr_pkg::CH_LF);
    send_byte(nmea_fr_pkg::CH_DOLLAR);
    repeat (nmea_fr_pkg::BUF_LEN - 1) send_byte(body_byte());
    send_byte(nmea_fr_pkg::CH_CR);
    send_byte(nmea_fr_pkg::CH_LF);
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_hold = 400;
    repeat (4) begin
      send_text("$GNGGA,");
      repeat (8) send_byte(body_byte());
      send_byte(nmea_fr_pkg::CH_CR);
      send_byte(nmea_fr_pkg::CH_LF);
    end
    wait_drain();
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned count);
    int unsigned stop_at;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = sent_bytes + count;
    while (sent_bytes < stop_at) send_random_sentence();
    wait_drain();
  endtask

  // Receiver: check each chunk transfer and pick ready for the next cycle.
  initial begin
    chunk_t want;
    chunk_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && chunk_if.valid && chunk_if.ready) begin
        chunks_seen++;
        if (expected_chunks.size() == 0) begin
          $error("unexpected chunk out_bytes=%h byte_count=%0d last=%0b",
                 chunk_if.out_bytes, chunk_if.byte_count, chunk_if.last);
          mismatches++;
        end else begin
          want = expected_chunks.pop_front();
          if (chunk_if.out_bytes !== want.out_bytes) begin
            $error("out_bytes expected %h actual %h", want.out_bytes, chunk_if.out_bytes);
            mismatches++;
          end
          if (chunk_if.byte_count !== want.byte_count) begin
            $error("byte_count expected %0d actual %0d", want.byte_count,
                   chunk_if.byte_count);
            mismatches++;
          end
          if (chunk_if.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, chunk_if.last);
            mismatches++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        chunk_if.ready <= 1'b0;
      end else begin
        chunk_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[nmea_sentence_framer_talker_rewrite_core] ERROR");
    $finish;
  end

  initial begin
    int unsigned budget;
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    sentence_fill = 0;
    sentence_prev = 8'h00;
    sink_hold = 0;
    sent_bytes = 0;
    framed_bytes = 0;
    chunks_seen = 0;
    mismatches = 0;
    src_idle_pct = 24;
    sink_idle_pct = 83;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_framing();
    test_talker_rewrite();
    test_length_limits();
    test_backpressure();
    budget = (TOTAL_ITEMS > sent_bytes) ? TOTAL_ITEMS - sent_bytes : 0;
    test_random(24, 83, budget / 3);
    test_random(83, 24, budget / 3);
    test_random(0, 0, budget - 2 * (budget / 3));
    $display("sent %0d bytes, %0d inside sentences, into %0d checked chunks, %0d mismatches",
             sent_bytes, framed_bytes, chunks_seen, mismatches);
    $display("covered framing errors, talker rewrite, length limits, output stall, random mix");
    if (mismatches == 0 && expected_chunks.size() == 0) begin
      $display("[nmea_sentence_framer_talker_rewrite_core] OK");
    end else begin
      $display("[nmea_sentence_framer_talker_rewrite_core] ERROR");
    end
    $finish;
  end

endmodule
